FILE: hw/rtl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg: shared constants for the window median filter
// Sizes of the configuration fields, register indexes and default values.
// ----------------------------------------------------------------------------
package wmf_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;
	localparam int unsigned DEF_MAX_RADIUS = 3;
	localparam int unsigned DEF_STORE_ROWS = 8;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned RAD_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic MODE_PIXEL = 1'b0;

endpackage

FILE: hw/rtl/window_median_filter.sv
// ----------------------------------------------------------------------------
// window_median_filter: clipped square-window median over a raster stream
// Pixels are written to a line store; each output is found by a bit-serial
// rank search that decides one result bit per pass over the window.
// ----------------------------------------------------------------------------
// flow: an item whose output is ready passes ST_STORE and ST_CHECK, then
// for an odd clipped window count n (at most 49) one rank search, for an even n two;
// one count pass, then 8 bit passes per rank, each value a read and a tally state.
// an item with no output returns to idle after ST_CHECK. one item is worked on at a time.
// reset: asynchronous, active low; counts cleared, registers to width 1,
// height 1, radius 1. the line store is not cleared.
module window_median_filter
	import wmf_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int unsigned STORE_ROWS = DEF_STORE_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // pixel_in
	input  logic                  s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // median_out
	output logic                  m_tlast    // last_pixel
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned CWS = (CW < 1) ? 1 : CW;
	localparam int unsigned RW = $clog2(STORE_ROWS);
	localparam int unsigned ROWW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned COLW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CAP0 = (STORE_ROWS - 2) / 2;
	localparam int unsigned RCAP = (MAX_RADIUS < CAP0) ? MAX_RADIUS : CAP0;
	localparam int unsigned NW = 8;
	localparam int unsigned ADDR_W = RW + CWS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_STORE, ST_CHECK, ST_READ, ST_DECIDE, ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [RAD_W-1:0]  radius_q;

	// effective sizes
	logic [COLW-1:0] w_eff;
	logic [ROWW-1:0] h_eff;
	logic [3:0]      r_eff;

	always_comb begin
		if (width_q == '0) w_eff = COLW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = COLW'(MAX_WIDTH);
		else w_eff = COLW'(width_q);
		if (height_q == '0) h_eff = ROWW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = ROWW'(MAX_HEIGHT);
		else h_eff = ROWW'(height_q);
		if (32'(radius_q) > RCAP) r_eff = 4'(RCAP);
		else r_eff = 4'(radius_q);
	end

	// receive position (row, col) and emit position
	logic [ROWW-1:0] rx_row_q, ex_row_q;
	logic [COLW-1:0] rx_col_q, ex_col_q;
	logic            rx_done_q;
	logic [RW-1:0]   rx_slot_q, ex_slot_q;

	// captured item
	logic       mode_q;
	logic [7:0] pix_q;

	// window bounds
	logic [ROWW-1:0] r0_q, r1_q, k_q;
	logic [COLW-1:0] c0_q, c1_q, l_q;
	logic [RW-1:0]   k_slot_q, r0_slot_q;

	// bit-serial rank search
	logic [7:0]    prefix_q;     // decided upper bits of the value
	logic [3:0]    bit_q;
	logic [NW-1:0] cnt_q;        // values below candidate
	logic [NW-1:0] n_q;
	logic [NW-1:0] rank_q;
	logic          second_q;     // working on upper middle rank
	logic          count_pass_q; // first pass counts n
	logic [7:0]    lo_val_q;
	logic          scan_end_q;

	// line store
	logic [7:0]        mem [STORE_ROWS * (1 << CWS)];
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	assign wr_addr = {rx_slot_q, CWS'(rx_col_q)};
	assign wr_en   = (state_q == ST_STORE) && (mode_q == MODE_PIXEL) && !rx_done_q;
	assign rd_addr = {k_slot_q, CWS'(l_q)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= pix_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	// store slot of the top window row
	logic [3:0]    back_rows;
	logic [RW-1:0] start_slot;

	always_comb begin
		back_rows = (ex_row_q >= ROWW'(r_eff)) ? r_eff : 4'(ex_row_q);
		if (32'(ex_slot_q) >= 32'(back_rows)) start_slot = ex_slot_q - RW'(back_rows);
		else start_slot = RW'(32'(ex_slot_q) + STORE_ROWS - 32'(back_rows));
	end

	// output readiness: received strictly beyond the need position, or all received
	logic [ROWW+3:0] need_row;
	logic [COLW+3:0] need_col;
	logic            out_ready;
	logic [ROWW-1:0] need_row_c;
	logic [COLW-1:0] need_col_c;

	always_comb begin
		need_row = (ROWW+4)'(ex_row_q) + (ROWW+4)'(r_eff);
		need_col = (COLW+4)'(ex_col_q) + (COLW+4)'(r_eff);
		need_row_c = (need_row > (ROWW+4)'(h_eff - 1'b1)) ? h_eff - 1'b1
			: ROWW'(need_row);
		need_col_c = (need_col > (COLW+4)'(w_eff - 1'b1)) ? w_eff - 1'b1
			: COLW'(need_col);
		if (rx_done_q) out_ready = 1'b1;
		else if (rx_row_q > need_row_c) out_ready = 1'b1;
		else out_ready = (rx_row_q == need_row_c) && (rx_col_q > need_col_c);
	end

	// candidate for current bit: prefix with this bit set, lower bits zero
	logic [7:0] cand;
	logic [7:0] mask;
	assign mask = 8'hFF << bit_q[2:0];
	assign cand = prefix_q | (8'h01 << bit_q[2:0]);

	logic at_last_elem;
	assign at_last_elem = (l_q == c1_q) && (k_q == r1_q);

	logic [7:0] mid_sum;
	assign mid_sum = 8'((9'(lo_val_q) + 9'(prefix_q)) >> 1);

	assign s_tready  = (state_q == ST_IDLE) && !m_tvalid;
	assign cfg_ready = (state_q == ST_IDLE) && !m_tvalid;

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			width_q   <= SIZE_W'(1);
			height_q  <= SIZE_W'(1);
			radius_q  <= RAD_W'(1);
			rx_row_q  <= '0;
			rx_col_q  <= '0;
			rx_slot_q <= '0;
			rx_done_q <= 1'b0;
			ex_row_q  <= '0;
			ex_col_q  <= '0;
			ex_slot_q <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tlast   <= 1'b0;
			mode_q <= 1'b0; pix_q <= '0;
			r0_q <= '0; r1_q <= '0; k_q <= '0; c0_q <= '0; c1_q <= '0; l_q <= '0;
			k_slot_q <= '0; r0_slot_q <= '0;
			prefix_q <= '0; bit_q <= '0; cnt_q <= '0; n_q <= '0; rank_q <= '0;
			second_q <= 1'b0; count_pass_q <= 1'b0; lo_val_q <= '0;
			scan_end_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						case (cfg_index)
							REG_WIDTH:  width_q <= cfg_data;
							REG_HEIGHT: height_q <= cfg_data;
							REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
							default: ;
						endcase
						if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
							cfg_index == REG_RADIUS) begin
							rx_row_q <= '0; rx_col_q <= '0; rx_slot_q <= '0;
							rx_done_q <= 1'b0; ex_row_q <= '0; ex_col_q <= '0;
							ex_slot_q <= '0;
						end
					end else if (s_tvalid && s_tready) begin
						mode_q  <= s_tuser;
						pix_q   <= s_tdata;
						state_q <= ST_STORE;
					end
				end
				// write pixel and advance receive position
				ST_STORE: begin
					if (mode_q == MODE_PIXEL && !rx_done_q) begin
						if (rx_col_q == w_eff - 1'b1) begin
							rx_col_q <= '0;
							if (rx_row_q == h_eff - 1'b1) rx_done_q <= 1'b1;
							else begin
								rx_row_q <= rx_row_q + 1'b1;
								rx_slot_q <= (rx_slot_q == RW'(STORE_ROWS - 1)) ? '0
									: rx_slot_q + 1'b1;
							end
						end else rx_col_q <= rx_col_q + 1'b1;
					end
					state_q <= ST_CHECK;
				end
				// window bounds; first pass counts the window
				ST_CHECK: begin
					if (!out_ready) state_q <= ST_IDLE;
					else begin
						r0_q <= (ex_row_q >= ROWW'(r_eff)) ? ex_row_q - ROWW'(r_eff) : '0;
						r1_q <= need_row_c;
						c0_q <= (ex_col_q >= COLW'(r_eff)) ? ex_col_q - COLW'(r_eff) : '0;
						c1_q <= need_col_c;
						r0_slot_q <= start_slot;
						k_q <= (ex_row_q >= ROWW'(r_eff)) ? ex_row_q - ROWW'(r_eff) : '0;
						l_q <= (ex_col_q >= COLW'(r_eff)) ? ex_col_q - COLW'(r_eff) : '0;
						k_slot_q <= start_slot;
						prefix_q <= '0;
						bit_q <= 4'd8;
						cnt_q <= '0;
						n_q <= '0;
						second_q <= 1'b0;
						count_pass_q <= 1'b1;
						state_q <= ST_READ;
					end
				end
				// one store read per value over the window
				ST_READ: begin
					scan_end_q <= at_last_elem;
					if (l_q == c1_q) begin
						l_q <= c0_q;
						k_q <= k_q + 1'b1;
						k_slot_q <= (k_slot_q == RW'(STORE_ROWS - 1)) ? '0
							: k_slot_q + 1'b1;
					end else l_q <= l_q + 1'b1;
					state_q <= ST_DECIDE;
				end
				// tally one value; at the end of a pass set the rank or decide a bit
				ST_DECIDE: begin
					logic [NW-1:0] cnt_n;
					cnt_n = cnt_q;
					if (count_pass_q) cnt_n = cnt_q + 1'b1;
					else if ((rd_data_q & mask) < cand) cnt_n = cnt_q + 1'b1;
					if (!scan_end_q) begin
						cnt_q <= cnt_n;
						state_q <= ST_READ;
					end else begin
						cnt_q <= '0;
						k_q <= r0_q;
						l_q <= c0_q;
						k_slot_q <= r0_slot_q;
						if (count_pass_q) begin
							n_q <= cnt_n;
							rank_q <= cnt_n[0] ? (cnt_n >> 1) : (cnt_n >> 1) - 1'b1;
							count_pass_q <= 1'b0;
							bit_q <= 4'd7;
							state_q <= ST_READ;
						end else begin
							logic [7:0] pnew;
							pnew = (cnt_n > rank_q) ? prefix_q : cand;
							if (bit_q != 4'd0) begin
								prefix_q <= pnew;
								bit_q <= bit_q - 1'b1;
								state_q <= ST_READ;
							end else if (!second_q && !n_q[0]) begin
								lo_val_q <= pnew;
								second_q <= 1'b1;
								rank_q <= n_q >> 1;
								prefix_q <= '0;
								bit_q <= 4'd7;
								state_q <= ST_READ;
							end else begin
								if (!second_q) lo_val_q <= pnew;
								prefix_q <= pnew;
								state_q <= ST_OUT;
							end
						end
					end
				end
				// present result and step emit position
				ST_OUT: begin
					logic fin;
					fin = (ex_col_q == w_eff - 1'b1) && (ex_row_q == h_eff - 1'b1);
					m_tvalid <= 1'b1;
					m_tdata  <= mid_sum;
					m_tlast  <= fin;
					if (fin) begin
						rx_row_q <= '0; rx_col_q <= '0; rx_slot_q <= '0;
						rx_done_q <= 1'b0; ex_row_q <= '0; ex_col_q <= '0;
						ex_slot_q <= '0;
					end else if (ex_col_q == w_eff - 1'b1) begin
						ex_col_q <= '0;
						ex_row_q <= ex_row_q + 1'b1;
						ex_slot_q <= (ex_slot_q == RW'(STORE_ROWS - 1)) ? '0
							: ex_slot_q + 1'b1;
					end else ex_col_q <= ex_col_q + 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// no new word taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while output pending");
	// a result only leaves the output stage
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("output valid without result stage");
	// receive column stays inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_col_q < w_eff || rx_done_q || $past(cfg_valid))
		else $error("receive column out of range");
`endif

endmodule
